// ===== hdl/rds_group_assembler_defines.svh =====
// ----------------------------------------------------------------------------
// RDS group assembler assertion macros
// Shared clocked assertion forms for the group assembler.
// ----------------------------------------------------------------------------
`ifndef RDS_GROUP_ASSEMBLER_DEFINES_SVH
`define RDS_GROUP_ASSEMBLER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define RGA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define RGA_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

// ===== hdl/rga_pkg.sv =====
// ----------------------------------------------------------------------------
// RDS group assembler package
// Item, result and status types and constants shared by the assembler.
// ----------------------------------------------------------------------------
package rga_pkg;

	localparam int NUM_BLOCKS = 4;
	localparam logic [2:0] POS_NONE = 3'd4;
	localparam logic [2:0] POS_LAST = 3'd3;
	localparam logic [7:0] DUR_RESET = 8'd22;
	localparam logic [1:0] ERR_INVALID = 2'd3;
	localparam logic REG_BLOCK_DURATION = 1'b0;

	typedef enum logic [1:0] {
		MODE_ARRIVAL = 2'd0,
		MODE_POLL    = 2'd1,
		MODE_CLEAR   = 2'd2,
		MODE_TICK    = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  block_index;
		logic [15:0] block_word;
		logic [1:0]  error_level;
	} item_t;

	typedef struct packed {
		logic [15:0] word_a;
		logic [15:0] word_b;
		logic [15:0] word_c;
		logic [15:0] word_d;
		logic [7:0]  error_byte;
		logic        group_ready;
	} result_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [2:0]  last_pos;
	} status_t;

endpackage

// ===== hdl/rga_cfg.sv =====
// ----------------------------------------------------------------------------
// RDS group assembler configuration register
// APB-style slave holding the block duration register.
// ----------------------------------------------------------------------------
module rga_cfg
	import rga_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  block_duration
);

	logic [7:0] dur_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCK_DURATION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= DUR_RESET;
		end else if (wr_en) begin
			dur_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_BLOCK_DURATION && paddr[1:0] == 2'd0) begin
			prdata = {24'd0, dur_q};
		end
	end

	assign block_duration = dur_q;

endmodule

// ===== hdl/rga_core.sv =====
// ----------------------------------------------------------------------------
// RDS group assembler core
// Group state, timeout compares and the update for one item.
// ----------------------------------------------------------------------------
module rga_core
	import rga_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  item_t      item,
	input  logic [7:0] block_duration,
	output result_t    result,
	output status_t    status
);

	logic [15:0] words_q [NUM_BLOCKS];
	logic [1:0]  err_q   [NUM_BLOCKS];
	logic [31:0] stamp_q [NUM_BLOCKS];
	logic [31:0] clear_q;
	logic [31:0] now_q;
	logic [2:0]  last_q;

	logic [15:0] next_word [NUM_BLOCKS];
	logic [1:0]  next_err  [NUM_BLOCKS];
	logic [2:0]  span      [NUM_BLOCKS];
	logic [10:0] limit     [NUM_BLOCKS];
	logic [31:0] age       [NUM_BLOCKS];
	logic        stale     [NUM_BLOCKS];
	logic        guard;
	logic [1:0]  k;
	logic [1:0]  p;
	logic [2:0]  poll_span;
	logic [10:0] poll_limit;
	logic        ready;

	assign k     = item.block_index;
	assign p     = last_q[1:0];
	assign guard = (now_q - clear_q) < {24'd0, block_duration};

	always_comb begin
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			span[i]  = {1'b0, k} + 3'd1 - 3'(i);
			limit[i] = {8'd0, span[i]} * {3'd0, block_duration};
			age[i]   = now_q - stamp_q[i];
			stale[i] = age[i] > {21'd0, limit[i]};
			if (2'(i) < k) begin
				next_word[i] = stale[i] ? 16'd0 : words_q[i];
				next_err[i]  = stale[i] ? ERR_INVALID : err_q[i];
			end else if (2'(i) == k) begin
				next_word[i] = item.block_word;
				next_err[i]  = item.error_level;
			end else begin
				next_word[i] = 16'd0;
				next_err[i]  = ERR_INVALID;
			end
		end
	end

	always_comb begin
		poll_span  = 3'd4 - {1'b0, p};
		poll_limit = {8'd0, poll_span} * {3'd0, block_duration};
		ready      = (last_q != POS_NONE) &&
			((last_q == POS_LAST) || ((now_q - stamp_q[p]) > {21'd0, poll_limit}));
		result = '0;
		if (ready) begin
			result.word_a      = words_q[0];
			result.word_b      = words_q[1];
			result.word_c      = words_q[2];
			result.word_d      = words_q[3];
			result.error_byte  = {err_q[0], err_q[1], err_q[2], err_q[3]};
			result.group_ready = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				words_q[i] <= 16'd0;
				err_q[i]   <= ERR_INVALID;
				stamp_q[i] <= 32'd0;
			end
			clear_q <= 32'd0;
			now_q   <= 32'd0;
			last_q  <= POS_NONE;
		end else if (fire) begin
			case (item.mode)
				MODE_ARRIVAL: begin
					if (!guard) begin
						for (int i = 0; i < NUM_BLOCKS; i++) begin
							words_q[i] <= next_word[i];
							err_q[i]   <= next_err[i];
						end
						stamp_q[k] <= now_q;
						last_q     <= {1'b0, k};
					end
				end
				MODE_POLL: begin
					if (ready) begin
						last_q <= POS_NONE;
					end
				end
				MODE_CLEAR: begin
					last_q  <= POS_NONE;
					clear_q <= now_q;
				end
				MODE_TICK: begin
					now_q <= now_q + 32'd1;
				end
				default: begin
					now_q <= now_q;
				end
			endcase
		end
	end

	assign status.now_ms   = now_q;
	assign status.last_pos = last_q;

endmodule

// ===== hdl/rds_group_assembler.sv =====
// ----------------------------------------------------------------------------
// RDS group assembler
// Collects RDS blocks A to D into one group with timeouts and resync.
//
//   channel  direction  handshake              items
//   s_*      in         s_tvalid / s_tready    arrival, poll, clear, tick
//   m_*      out        m_tvalid / m_tready    one result per poll
//   apb      in         psel/penable/pwrite    block duration register
//
// One item per cycle; the input stage does the state update and the four
// timeout compares, and a poll result then sits in the output register
// until taken.
// The input stage stalls only while it holds a poll and the output
// register is full and not being taken.
// Asynchronous reset clears the group state and counter and sets the duration to 22 ms.
// ----------------------------------------------------------------------------
`include "rds_group_assembler_defines.svh"

module rds_group_assembler
	import rga_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // block_index, block_word, error_level, zero pad
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // word_a, word_b, word_c, word_d, error_byte
	output logic        m_tuser,   // group_ready
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	item_t      item_s1;
	logic       valid_s1;
	logic       adv;
	logic       fire;
	logic [7:0] block_duration;
	result_t    result;
	status_t    status;
	result_t    out_q;
	logic       out_valid_q;

	rga_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.block_duration (block_duration)
	);

	rga_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.item           (item_s1),
		.block_duration (block_duration),
		.result         (result),
		.status         (status)
	);

	assign adv      = !(item_s1.mode == MODE_POLL && out_valid_q && !m_tready);
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode        <= mode_t'(s_tuser);
			item_s1.block_index <= s_tdata[1:0];
			item_s1.block_word  <= s_tdata[17:2];
			item_s1.error_level <= s_tdata[19:18];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && item_s1.mode == MODE_POLL) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item_s1.mode == MODE_POLL) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.error_byte, out_q.word_d, out_q.word_c, out_q.word_b,
		out_q.word_a};
	assign m_tuser  = out_q.group_ready;

	`RGA_ASSERT_IMP(a_empty_poll_zero, m_tvalid && !m_tuser, m_tdata == 72'd0,
		"empty poll result carries data")
	`RGA_ASSERT(a_tick_counts,
		fire && item_s1.mode == MODE_TICK |=> status.now_ms == $past(status.now_ms) + 32'd1,
		"tick did not advance the counter")
	`RGA_ASSERT(a_release_clears,
		fire && item_s1.mode == MODE_POLL && result.group_ready |=> status.last_pos == POS_NONE,
		"released group left a last position")
	`RGA_ASSERT_IMP(a_pos_range, 1'b1, status.last_pos <= POS_NONE,
		"last position out of range")

endmodule
